@@ hdl/bse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg: shared definitions of the bech32m string encoder
// Request and status codes, the command that crosses from the front to the
// back, the back's state type, and the checksum and charset functions.
// ----------------------------------------------------------------------------
package bse_pkg;

	// Defaults of the top-level parameters.
	localparam int DEF_MAX_PREFIX  = 83;
	localparam int DEF_MAX_SYMBOLS = 1024;

	// Prefix counts are carried in a field wide enough for the largest limit.
	localparam int CNT_W = 7;

	// Depth of the command queue between front and back.
	localparam int FIFO_DEPTH = 4;

	// Request codes of an input beat.
	localparam logic [1:0] REQ_PREFIX = 2'd0;
	localparam logic [1:0] REQ_DATA   = 2'd1;
	localparam logic [1:0] REQ_END    = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	// Status codes of an output beat.
	localparam logic [2:0] STATUS_OK           = 3'd0;
	localparam logic [2:0] STATUS_EMPTY_PREFIX = 3'd1;
	localparam logic [2:0] STATUS_PREFIX_LONG  = 3'd2;
	localparam logic [2:0] STATUS_DATA_LONG    = 3'd3;
	localparam logic [2:0] STATUS_PREFIX_AFTER = 3'd4;

	// Characters with a fixed role.
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;
	localparam logic [7:0] CHAR_SEP     = 8'h31;
	localparam logic [7:0] CHAR_NONE    = 8'h00;

	// Checksum constants.
	localparam logic [29:0] CHECK_INIT = 30'h0000_0001;
	localparam logic [29:0] CHECK_XOR  = 30'h2bc8_30a3;
	localparam logic [29:0] GEN [5] = '{
		30'h3b6a_57b2, 30'h2650_8e6d, 30'h1ea1_19fa, 30'h3d42_33dd, 30'h2a14_62b3
	};

	// Symbol alphabet, first character in the top byte.
	localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

	// Command operations.
	typedef enum logic [1:0] {
		CMD_PREFIX,
		CMD_DATA,
		CMD_END,
		CMD_ERROR
	} cmd_op_t;

	// One command from the front to the back.
	typedef struct packed {
		cmd_op_t          op;
		logic [7:0]       value;  // lower-cased prefix character or data byte
		logic             sep;    // emit the separator and replay the prefix first
		logic [CNT_W-1:0] plen;   // prefix store address or replay length
		logic [2:0]       status; // error code of an error command
	} cmd_t;

	// States of the back sequencer.
	typedef enum logic [3:0] {
		BK_IDLE,
		BK_PREFIX,
		BK_ERROR,
		BK_SEP,
		BK_REPLAY,
		BK_LOAD,
		BK_SYM,
		BK_PAD,
		BK_ZERO,
		BK_CHECK
	} bk_state_t;

	// One step of the GF(32) polymod.
	function automatic logic [29:0] bse_fold(input logic [29:0] acc, input logic [4:0] sym);
		logic [29:0] r;
		r = {acc[24:0], sym};
		for (int k = 0; k < 5; k++) begin
			if (acc[25 + k]) begin
				r = r ^ GEN[k];
			end
		end
		return r;
	endfunction

	// Character of a 5-bit symbol.
	function automatic logic [7:0] bse_char(input logic [4:0] s);
		return CHARSET[8 * (31 - int'(s)) +: 8];
	endfunction

endpackage
`default_nettype wire

@@ hdl/bse_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_stream_if: input and output channels of the bech32m string encoder
// Each channel carries valid, ready and its payload; a beat moves at a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bse_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink (input valid, input req_type, input value, output ready);
endinterface

interface bse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;
	logic [2:0] status;

	modport source (output valid, output out_char, output last, output status, input ready);
	modport sink (input valid, input out_char, input last, input status, output ready);
endinterface
`default_nettype wire

@@ hdl/bse_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_front: request classifier
// Accepts input beats, tracks prefix length, phase, pending bit count and
// symbol count, detects the error cases and queues one command per prefix, data or end request.
// ----------------------------------------------------------------------------
module bse_front import bse_pkg::*; #(
	parameter int MAX_PREFIX  = DEF_MAX_PREFIX,
	parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
	input  logic     clk,
	input  logic     arst_n,
	bse_in_if.sink   in_ch,
	input  logic     fifo_full,
	output logic     push,
	output cmd_t     push_data
);

	localparam int SW   = $clog2(MAX_SYMBOLS + 1);
	localparam int SUMW = SW + 1;

	logic [CNT_W-1:0] pc_q, pc_d;
	logic             data_q, data_d;
	logic [2:0]       fb_q, fb_d;
	logic [SW-1:0]    sc_q, sc_d;
	logic             accept;
	logic [7:0]       lc;
	logic [3:0]       fb_plus;
	logic [1:0]       need;
	logic [SUMW-1:0]  sum;
	logic             fail;
	logic [2:0]       code;

	assign in_ch.ready = !fifo_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// Lower casing of prefix characters and symbol demand of the request.
	always_comb begin
		lc      = (in_ch.value >= CHAR_UPPER_A && in_ch.value <= CHAR_UPPER_Z) ?
		          in_ch.value + CASE_OFFSET : in_ch.value;
		fb_plus = {1'b0, fb_q} + 4'd8;
		if (in_ch.req_type == REQ_DATA) begin
			need = (fb_q >= 3'd2) ? 2'd2 : 2'd1;
		end else begin
			need = (fb_q != 3'd0) ? 2'd1 : 2'd0;
		end
		sum = {1'b0, sc_q} + SUMW'(need);
	end

	// Classification and next values of the tracking state.
	always_comb begin
		pc_d      = pc_q;
		data_d    = data_q;
		fb_d      = fb_q;
		sc_d      = sc_q;
		fail      = 1'b0;
		code      = STATUS_OK;
		push      = 1'b0;
		push_data = '{op: CMD_ERROR, value: lc, sep: !data_q, plen: pc_q, status: STATUS_OK};
		unique case (in_ch.req_type) inside
			REQ_PREFIX: begin
				push = accept;
				if (data_q) begin
					fail = 1'b1;
					code = STATUS_PREFIX_AFTER;
				end else if (pc_q >= CNT_W'(MAX_PREFIX)) begin
					fail = 1'b1;
					code = STATUS_PREFIX_LONG;
				end else begin
					push_data.op = CMD_PREFIX;
					pc_d         = pc_q + 1'b1;
				end
			end
			REQ_DATA, REQ_END: begin
				push = accept;
				if (!data_q && pc_q == '0) begin
					fail = 1'b1;
					code = STATUS_EMPTY_PREFIX;
				end else if (sum > SUMW'(MAX_SYMBOLS)) begin
					fail = 1'b1;
					code = STATUS_DATA_LONG;
				end else if (in_ch.req_type == REQ_DATA) begin
					push_data.op    = CMD_DATA;
					push_data.value = in_ch.value;
					data_d          = 1'b1;
					fb_d            = (need == 2'd2) ? 3'(fb_plus - 4'd10) : 3'(fb_plus - 4'd5);
					sc_d            = sum[SW-1:0];
				end else begin
					push_data.op = CMD_END;
					pc_d         = '0;
					data_d       = 1'b0;
					fb_d         = '0;
					sc_d         = '0;
				end
			end
			REQ_NONE: begin
				push = 1'b0;
			end
			default: begin
				push = 1'b0;
			end
		endcase
		if (fail) begin
			push_data.op     = CMD_ERROR;
			push_data.status = code;
			pc_d             = '0;
			data_d           = 1'b0;
			fb_d             = '0;
			sc_d             = '0;
		end
	end

	// Tracking state advances on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			data_q <= 1'b0;
			fb_q   <= '0;
			sc_q   <= '0;
		end else if (accept) begin
			pc_q   <= pc_d;
			data_q <= data_d;
			fb_q   <= fb_d;
			sc_q   <= sc_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/bse_cmd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_cmd_fifo: command queue
// A short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module bse_cmd_fifo import bse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	cmd_t          slot_q [FIFO_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = count_q == CW'(FIFO_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ hdl/bse_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_back: encoding sequencer
// Carries out queued commands one at a time: echoes prefix characters, stores
// their low parts, replays the prefix into the polymod, regroups data into
// symbols, emits the checksum or an error beat through an output register.
// ----------------------------------------------------------------------------
module bse_back import bse_pkg::*; #(
	parameter int MAX_PREFIX = DEF_MAX_PREFIX
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fifo_empty,
	input  cmd_t      fifo_data,
	output logic      fifo_pop,
	bse_out_if.source out_ch
);

	localparam int AW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;

	bk_state_t        state_q, state_d;
	cmd_t             cmd_q;
	logic [29:0]      check_q;
	logic [11:0]      bacc_q;
	logic [3:0]       bcnt_q;
	logic [CNT_W-1:0] ridx_q;
	logic [2:0]       step_q;
	logic [4:0]       mem [MAX_PREFIX];
	logic [4:0]       rdata_q;
	logic             ovalid_q;
	logic [7:0]       ochar_q;
	logic             olast_q;
	logic [2:0]       ostat_q;
	logic             can_emit;
	logic             emit;
	logic [7:0]       e_char;
	logic             e_last;
	logic [2:0]       e_stat;
	logic             mem_we;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [3:0]       rem;
	logic [4:0]       data_sym;
	logic [4:0]       pad_sym;
	logic             replay_done;

	assign can_emit    = !ovalid_q || out_ch.ready;
	assign rem         = bcnt_q - 4'd5;
	assign data_sym    = 5'(bacc_q >> rem);
	assign pad_sym     = 5'(bacc_q << (4'd5 - bcnt_q));
	assign replay_done = ridx_q == cmd_q.plen;

	assign out_ch.valid    = ovalid_q;
	assign out_ch.out_char = ochar_q;
	assign out_ch.last     = olast_q;
	assign out_ch.status   = ostat_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!fifo_empty) begin
					unique case (fifo_data.op)
						CMD_PREFIX: state_d = BK_PREFIX;
						CMD_ERROR:  state_d = BK_ERROR;
						CMD_DATA:   state_d = fifo_data.sep ? BK_SEP : BK_LOAD;
						CMD_END:    state_d = fifo_data.sep ? BK_SEP : BK_PAD;
						default:    state_d = BK_ERROR;
					endcase
				end
			end
			BK_PREFIX, BK_ERROR: begin
				if (can_emit) begin
					state_d = BK_IDLE;
				end
			end
			BK_SEP: begin
				if (can_emit) begin
					state_d = BK_REPLAY;
				end
			end
			BK_REPLAY: begin
				if (replay_done) begin
					state_d = (cmd_q.op == CMD_DATA) ? BK_LOAD : BK_PAD;
				end
			end
			BK_LOAD: state_d = BK_SYM;
			BK_SYM: begin
				if (can_emit && rem < 4'd5) begin
					state_d = BK_IDLE;
				end
			end
			BK_PAD: begin
				if (bcnt_q == 4'd0 || can_emit) begin
					state_d = BK_ZERO;
				end
			end
			BK_ZERO: begin
				if (step_q == 3'd5) begin
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (can_emit && step_q == 3'd5) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs of each state: emitted beat, queue pop and store access.
	always_comb begin
		emit      = 1'b0;
		e_char    = CHAR_NONE;
		e_last    = 1'b0;
		e_stat    = STATUS_OK;
		fifo_pop  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			BK_IDLE: fifo_pop = !fifo_empty;
			BK_PREFIX: begin
				emit   = can_emit;
				e_char = cmd_q.value;
				mem_we = can_emit;
			end
			BK_ERROR: begin
				emit   = can_emit;
				e_last = 1'b1;
				e_stat = cmd_q.status;
			end
			BK_SEP: begin
				emit   = can_emit;
				e_char = CHAR_SEP;
				mem_re = can_emit;
			end
			BK_REPLAY: begin
				mem_re    = !replay_done;
				mem_raddr = ridx_q[AW-1:0];
			end
			BK_LOAD: emit = 1'b0;
			BK_SYM: begin
				emit   = can_emit;
				e_char = bse_char(data_sym);
			end
			BK_PAD: begin
				emit   = can_emit && bcnt_q != 4'd0;
				e_char = bse_char(pad_sym);
			end
			BK_ZERO: emit = 1'b0;
			BK_CHECK: begin
				emit   = can_emit;
				e_char = bse_char(check_q[29:25]);
				e_last = step_q == 3'd5;
			end
			default: emit = 1'b0;
		endcase
	end

	// Sequencer state, polymod, bit regrouping and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			check_q  <= CHECK_INIT;
			bacc_q   <= '0;
			bcnt_q   <= '0;
			ridx_q   <= '0;
			step_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: ridx_q <= ridx_q;
				BK_PREFIX: begin
					if (can_emit) begin
						check_q <= bse_fold(check_q, {2'b00, cmd_q.value[7:5]});
					end
				end
				BK_ERROR: begin
					if (can_emit) begin
						check_q <= CHECK_INIT;
						bcnt_q  <= '0;
					end
				end
				BK_SEP: begin
					if (can_emit) begin
						check_q <= bse_fold(check_q, 5'd0);
						ridx_q  <= CNT_W'(1);
					end
				end
				BK_REPLAY: begin
					check_q <= bse_fold(check_q, rdata_q);
					ridx_q  <= ridx_q + 1'b1;
				end
				BK_LOAD: begin
					bacc_q <= {bacc_q[3:0], cmd_q.value};
					bcnt_q <= bcnt_q + 4'd8;
				end
				BK_SYM: begin
					if (can_emit) begin
						check_q <= bse_fold(check_q, data_sym);
						bcnt_q  <= rem;
					end
				end
				BK_PAD: begin
					if (bcnt_q != 4'd0 && can_emit) begin
						check_q <= bse_fold(check_q, pad_sym);
					end
					if (bcnt_q == 4'd0 || can_emit) begin
						bcnt_q <= '0;
						step_q <= '0;
					end
				end
				BK_ZERO: begin
					if (step_q == 3'd5) begin
						check_q <= bse_fold(check_q, 5'd0) ^ CHECK_XOR;
						step_q  <= '0;
					end else begin
						check_q <= bse_fold(check_q, 5'd0);
						step_q  <= step_q + 1'b1;
					end
				end
				BK_CHECK: begin
					if (can_emit) begin
						if (step_q == 3'd5) begin
							check_q <= CHECK_INIT;
							step_q  <= '0;
						end else begin
							check_q <= {check_q[24:0], 5'd0};
							step_q  <= step_q + 1'b1;
						end
					end
				end
				default: ridx_q <= ridx_q;
			endcase
		end
	end

	// Command register and output payload.
	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			cmd_q <= fifo_data;
		end
		if (emit) begin
			ochar_q <= e_char;
			olast_q <= e_last;
			ostat_q <= e_stat;
		end
	end

	// Store of the low parts of the prefix characters.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd_q.plen[AW-1:0]] <= cmd_q.value[4:0];
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/bech32m_string_encoder_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bech32m_string_encoder_top: streaming bech32m string encoder
// Turns a stream of prefix characters, data bytes and end markers into the
// characters of a bech32m string with its checksum.
// ----------------------------------------------------------------------------
//
//  Channel  Role    Payload                     Beat
//  in_ch    sink    req_type[1:0], value[7:0]   one request
//  out_ch   source  out_char[7:0], last, status  one character or error
//
// A prefix character is popped and echoed; a data byte is popped, loaded
// and sent as one or two symbols; the first data or end item first emits
// the separator and replays the prefix through the single store read port.
// An end item emits a pad symbol if bits remain, runs six zero steps and
// sends six checksum characters. A 4-entry command queue lets the front keep
// accepting while the back works or the output stalls. Reset clears all
// control state; the prefix store needs no clearing.
//
module bech32m_string_encoder_top import bse_pkg::*; #(
	parameter int MAX_PREFIX  = DEF_MAX_PREFIX,
	parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
	input  logic      clk,
	input  logic      arst_n,
	bse_in_if.sink    in_ch,
	bse_out_if.source out_ch
);

	logic push;
	cmd_t push_data;
	logic full;
	logic pop;
	cmd_t pop_data;
	logic empty;

	// Front: classifies requests into commands.
	bse_front #(
		.MAX_PREFIX  (MAX_PREFIX),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.fifo_full (full),
		.push      (push),
		.push_data (push_data)
	);

	// Queue between front and back.
	bse_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// Back: emits the characters.
	bse_back #(
		.MAX_PREFIX (MAX_PREFIX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (empty),
		.fifo_data  (pop_data),
		.fifo_pop   (pop),
		.out_ch     (out_ch)
	);

endmodule
`default_nettype wire

@@ hdl/bse_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bse_checker: port checks of the bech32m string encoder
// Watches the output channel for beat hold and for the form of error and
// checksum beats.
// ----------------------------------------------------------------------------
module bse_checker import bse_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_char,
	input wire logic       last,
	input wire logic [2:0] status
);

	// A stalled beat stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat withdrawn while stalled");

	// A stalled beat keeps its payload.
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char) && $stable(last) && $stable(status))
		else $error("output payload changed while stalled");

	// An error beat carries no character and closes the run.
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> out_char == CHAR_NONE && last)
		else $error("error beat with a character or without last");

	// The closing checksum character is a digit or a lower-case letter.
	a_check_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && status == STATUS_OK |->
		(out_char >= 8'h30 && out_char <= 8'h39) || (out_char >= 8'h61 && out_char <= 8'h7a))
		else $error("final checksum character outside the alphabet");

endmodule

bind bech32m_string_encoder_top bse_checker u_bse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char),
	.last      (out_ch.last),
	.status    (out_ch.status)
);
`default_nettype wire
